// File: design/sm3_pkg.sv
`default_nettype none

package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [511:0] block_t;
  typedef word_t chain_t [8];

  // One block for the compression core; last asks for the digest after it.
  typedef struct packed {
    block_t block;
    logic   last;
  } job_t;

  localparam int QUEUE_DEPTH = 2;

  localparam word_t T_LOW  = 32'h79cc4519;
  localparam word_t T_HIGH = 32'h7a879d8a;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam chain_t SM3_IV = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  function automatic word_t rol32(input word_t x, input int unsigned n);
    if (n == 0) begin
      return x;
    end
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

  // Round constant rotated by j mod 32; upper half of the doubled word.
  function automatic word_t tj_rot(input logic [5:0] j);
    logic [63:0] dbl;
    word_t       t;
    t   = (j < 6'd16) ? T_LOW : T_HIGH;
    dbl = {t, t} << j[4:0];
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

// File: design/sm3_front.sv
`default_nettype none

module sm3_front
  import sm3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       msg_valid,
  output logic            msg_stall,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output logic            push_valid,
  input  wire logic       push_stall,
  output job_t            push_job
);

  logic [7:0]  block_buffer [64];
  logic [5:0]  fill;
  logic [63:0] bit_total;
  logic        pad2;
  logic        accept;
  block_t      blk_data;
  block_t      blk_pad;

  // pad2: finish spilled into a second, length-only block
  assign msg_stall = push_stall | pad2;
  assign accept    = msg_valid & ~msg_stall;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      blk_data[511 - 8*i -: 8] = (6'(i) == fill) ? data_byte : block_buffer[i];
      if (6'(i) < fill) begin
        blk_pad[511 - 8*i -: 8] = block_buffer[i];
      end else if (6'(i) == fill) begin
        blk_pad[511 - 8*i -: 8] = PAD_BYTE;
      end else begin
        blk_pad[511 - 8*i -: 8] = 8'h00;
      end
    end
    if (fill < LEN_START) begin
      blk_pad[63:0] = bit_total;
    end
  end

  always_comb begin
    push_valid = 1'b0;
    push_job   = '{block: blk_data, last: 1'b0};
    if (pad2) begin
      push_valid = 1'b1;
      push_job   = '{block: {448'b0, bit_total}, last: 1'b1};
    end else if (accept && !op) begin
      push_valid = (fill == LAST_ROUND);
    end else if (accept && op) begin
      push_valid = 1'b1;
      push_job   = '{block: blk_pad, last: (fill < LEN_START)};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !op) begin
      block_buffer[fill] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_total <= '0;
      pad2      <= 1'b0;
    end else if (pad2) begin
      if (!push_stall) begin
        pad2      <= 1'b0;
        fill      <= '0;
        bit_total <= '0;
      end
    end else if (accept && !op) begin
      fill      <= fill + 6'd1;
      bit_total <= bit_total + 64'd8;
    end else if (accept && op) begin
      if (fill < LEN_START) begin
        fill      <= '0;
        bit_total <= '0;
      end else begin
        pad2 <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/sm3_queue.sv
`default_nettype none

module sm3_queue
  import sm3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_stall,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_stall,
  output job_t      pop_job
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid & ~push_stall;
  assign do_pop     = pop_valid & ~pop_stall;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/sm3_core.sv
`default_nettype none

module sm3_core
  import sm3_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   job_valid,
  output logic        job_stall,
  input  wire job_t   job,
  output logic        dig_valid,
  input  wire logic   dig_stall,
  output logic [63:0] digest_part,
  output logic [1:0]  part_index,
  output logic        last_part
);

  typedef enum logic [1:0] {IDLE, ROUND, FOLD, EMIT} state_t;

  state_t     state;
  chain_t     chain;
  word_t      v [8];
  word_t      w [16];
  logic [5:0] j;
  logic [1:0] part;
  logic       last_job;

  word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_next;

  assign job_stall   = (state != IDLE);
  assign part_index  = part;
  assign last_part   = (part == 2'd3);
  assign digest_part = {chain[{part, 1'b0}], chain[{part, 1'b1}]};

  always_comb begin
    a12 = rol32(v[0], 12);
    ss1 = rol32(a12 + v[4] + tj_rot(j), 7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = v[0] ^ v[1] ^ v[2];
      gg = v[4] ^ v[5] ^ v[6];
    end else begin
      ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      gg = (v[4] & v[5]) | (~v[4] & v[6]);
    end
    tt1 = ff + v[3] + ss2 + (w[0] ^ w[4]);
    tt2 = gg + v[7] + ss1 + w[0];
    // window holds W[j..j+15]; next expanded word enters at the top
    w_next = perm1(w[0] ^ w[7] ^ rol32(w[13], 15)) ^ rol32(w[3], 7) ^ w[10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      chain     <= SM3_IV;
      dig_valid <= 1'b0;
      part      <= '0;
      j         <= '0;
      last_job  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 16; i++) begin
              w[i] <= job.block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
              v[i] <= chain[i];
            end
            last_job <= job.last;
            j        <= '0;
            state    <= ROUND;
          end
        end
        ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_next;
          v[0] <= tt1;
          v[1] <= v[0];
          v[2] <= rol32(v[1], 9);
          v[3] <= v[2];
          v[4] <= perm0(tt2);
          v[5] <= v[4];
          v[6] <= rol32(v[5], 19);
          v[7] <= v[6];
          j    <= j + 6'd1;
          if (j == LAST_ROUND) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] ^ v[i];
          end
          if (last_job) begin
            part      <= '0;
            dig_valid <= 1'b1;
            state     <= EMIT;
          end else begin
            state <= IDLE;
          end
        end
        EMIT: begin
          if (!dig_stall) begin
            if (part == 2'd3) begin
              dig_valid <= 1'b0;
              chain     <= SM3_IV;
              part      <= '0;
              state     <= IDLE;
            end else begin
              part <= part + 2'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ROUND && j != LAST_ROUND) |=> (state == ROUND && j == 6'($past(j) + 6'd1)))
    else $error("round counter skipped");

  a_valid_only_emit: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (state == EMIT))
    else $error("digest valid outside emit");

  a_iv_after_digest: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && part == 2'd3) |=> (!dig_valid && chain[0] == SM3_IV[0]))
    else $error("chain not restored after digest");
`endif

endmodule

`default_nettype wire

// File: design/sm3_hash_engine_top.sv
`default_nettype none

// SM3 hash engine. A request carries op 0 with one message byte, or op 1 to
// finish the message. Bytes are taken one per cycle, while msg_stall is low,
// into a 64-byte block; each full block (and the one or two padded blocks
// built at finish) goes into a two-block queue, and the compression core
// works a block in one load, 64 rounds at one per cycle and one fold into
// the chaining state; it takes no new block until it is through with the
// last one. msg_stall rises only while both queue slots are full or while
// a finish that overflowed into a second pad block is queued. After the last
// block of a message the digest comes out as four 64-bit parts, most
// significant first, and the core returns to the IV; bytes of the following
// message keep filling the front block meanwhile.
module sm3_hash_engine_top
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [63:0]      digest_part,
  output logic [1:0]       part_index,
  output logic             last_part
);

  logic push_valid, push_stall;
  logic pop_valid, pop_stall;
  job_t push_job, pop_job;

  sm3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .op         (op),
    .data_byte  (data_byte),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_job   (push_job)
  );

  sm3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_job    (pop_job)
  );

  sm3_core u_core (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (pop_valid),
    .job_stall   (pop_stall),
    .job         (pop_job),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_part (digest_part),
    .part_index  (part_index),
    .last_part   (last_part)
  );

endmodule

`default_nettype wire

// File: bench/sm3_hash_engine_top_tb.sv
`default_nettype none

module sm3_hash_engine_top_tb
  import sm3_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [255:0] DIGEST_EMPTY =
    256'h1ab21d83_55cfa17f_8e611948_31e81a8f_22bec8c7_28fefb74_7ed035eb_5082aa2b;
  localparam logic [255:0] DIGEST_ABC =
    256'h66c7f0f4_62eeedd9_d1f2d46b_dc10e4e2_4167c487_5cf2f7a2_297da02b_8f4ba8e0;

  typedef struct packed {
    logic [63:0] part;
    logic [1:0]  idx;
    logic        last;
  } digest_part_t;

  typedef struct packed {
    logic         op;
    logic [7:0]   data;
    logic         typed;
    logic [255:0] digest;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic        op = OP_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        dig_valid;
  logic        dig_stall = 1'b0;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        last_part;

  logic calm = 1'b0;
  logic hold_go = 1'b0;
  int   errors = 0;
  int   n_sent = 0;
  int   quiet = 0;

  digest_part_t digest_q[$];

  // predictor state
  chain_t      chain_st;
  logic [7:0]  msg_buf [64];
  int unsigned fill_n;
  logic [63:0] bit_len;

  dir_row_t dir_rows [12] = '{
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{OP_ABSORB, 8'h61, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h62, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h63, 1'b0, 256'h0},
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_ABC},
    '{OP_ABSORB, 8'h00, 1'b0, 256'h0},
    '{OP_ABSORB, 8'hff, 1'b0, 256'h0},
    '{OP_FINISH, 8'hff, 1'b0, 256'h0},
    '{OP_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{OP_ABSORB, 8'h80, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{OP_FINISH, 8'h5a, 1'b0, 256'h0}
  };

  sm3_hash_engine_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .op          (op),
    .data_byte   (data_byte),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_part (digest_part),
    .part_index  (part_index),
    .last_part   (last_part)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) begin
      return x;
    end
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] mix0(input logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] mix1(input logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  function automatic void sm3_restart();
    chain_st = SM3_IV;
    fill_n   = 0;
    bit_len  = 64'd0;
  endfunction

  function automatic void sm3_compress();
    logic [31:0] w [68];
    logic [31:0] wx [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    end
    for (int i = 16; i < 68; i++) begin
      w[i] = mix1(w[i-16] ^ w[i-9] ^ rotl(w[i-3], 15)) ^ rotl(w[i-13], 7) ^ w[i-6];
    end
    for (int i = 0; i < 64; i++) begin
      wx[i] = w[i] ^ w[i+4];
    end
    a = chain_st[0]; b = chain_st[1]; c = chain_st[2]; d = chain_st[3];
    e = chain_st[4]; f = chain_st[5]; g = chain_st[6]; h = chain_st[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? T_LOW : T_HIGH;
      a12 = rotl(a, 12);
      ss1 = rotl(a12 + e + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + wx[j];
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rotl(b, 9); b = a; a = tt1;
      h = g; g = rotl(f, 19); f = e; e = mix0(tt2);
    end
    chain_st[0] ^= a; chain_st[1] ^= b; chain_st[2] ^= c; chain_st[3] ^= d;
    chain_st[4] ^= e; chain_st[5] ^= f; chain_st[6] ^= g; chain_st[7] ^= h;
  endfunction

  function automatic void sm3_absorb(input logic [7:0] b);
    msg_buf[fill_n] = b;
    fill_n++;
    bit_len += 64'd8;
    if (fill_n == 64) begin
      sm3_compress();
      fill_n = 0;
    end
  endfunction

  function automatic logic [255:0] sm3_close();
    int unsigned   pos;
    logic [255:0] dig;
    pos = fill_n;
    msg_buf[pos] = PAD_BYTE;
    pos++;
    // length field does not fit: spill into an extra block
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) msg_buf[i] = 8'h00;
      sm3_compress();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) msg_buf[i] = 8'h00;
    for (int k = 0; k < 8; k++) msg_buf[56+k] = bit_len[63-8*k -: 8];
    sm3_compress();
    dig = {chain_st[0], chain_st[1], chain_st[2], chain_st[3],
           chain_st[4], chain_st[5], chain_st[6], chain_st[7]};
    sm3_restart();
    return dig;
  endfunction

  function automatic void queue_digest(input logic [255:0] dig);
    digest_part_t p;
    for (int k = 0; k < 4; k++) begin
      p.part = dig[255-64*k -: 64];
      p.idx  = k[1:0];
      p.last = (k == 3);
      digest_q.push_back(p);
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH: %s", what);
    end
  endtask

  task automatic push_request(input logic op_v, input logic [7:0] byte_v,
                              input logic typed_v, input logic [255:0] typed_dig);
    logic [255:0] dig;
    if (!calm && $urandom_range(0, 4) == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    msg_valid <= 1'b1;
    op        <= op_v;
    data_byte <= byte_v;
    do @(posedge clk); while (msg_stall);
    n_sent++;
    if (op_v == OP_ABSORB) begin
      sm3_absorb(byte_v);
    end else begin
      dig = sm3_close();
      if (typed_v) dig = typed_dig;
      queue_digest(dig);
    end
  endtask

  // stimulus
  initial begin
    int len;
    int pick;
    sm3_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      push_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed,
                   dir_rows[i].digest);
    end

    // let everything drain before the random part
    msg_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);

    hold_go <= 1'b1;
    while (n_sent < 158) begin
      pick = $urandom_range(0, 9);
      case (pick)
        6: len = $urandom_range(55, 56);
        7: len = $urandom_range(63, 65);
        8: len = $urandom_range(56, 63);
        9: len = 0;
        default: len = $urandom_range(0, 12);
      endcase
      // keep the total near the planned item count
      if (len > 171 - n_sent) len = 171 - n_sent;
      for (int i = 0; i < len; i++) begin
        push_request(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      end
      push_request(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      if (n_sent >= 130 && !calm) calm <= 1'b1;
    end

    msg_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sm3_hash_engine_top_tb passed");
    end else begin
      $display("sm3_hash_engine_top_tb failed");
    end
    $finish;
  end

  // digest side back-pressure
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        // long hold-off so the queue fills and the request side stalls
        dig_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        dig_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        dig_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        dig_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    digest_part_t want;
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest part %h idx %0d last %0d",
                                  digest_part, part_index, last_part));
      end else begin
        want = digest_q.pop_front();
        if (digest_part !== want.part || part_index !== want.idx ||
            last_part !== want.last) begin
          report_mismatch($sformatf("got %h/%0d/%0d want %h/%0d/%0d",
                                    digest_part, part_index, last_part,
                                    want.part, want.idx, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("sm3_hash_engine_top_tb failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// File: sim.f
design/sm3_pkg.sv
design/sm3_front.sv
design/sm3_queue.sv
design/sm3_core.sv
design/sm3_hash_engine_top.sv
bench/sm3_hash_engine_top_tb.sv
